// ----- sv/qgp_pkg.sv -----
`default_nettype none
package qgp_pkg;

  // One in Q2.30 and the Newton constants.
  localparam logic [31:0] QONE       = 32'd1073741824;
  localparam logic [33:0] THREE_QONE = 34'd3221225472;
  localparam logic [31:0] Y0_LOW     = 32'd939524096;
  localparam logic [31:0] Y0_HIGH    = 32'd671088640;
  localparam logic [31:0] HSTEP_RST  = 32'd4294967;

  // Renormalization exponent codes.
  localparam logic [1:0] EXP_DOWN = 2'd0;
  localparam logic [1:0] EXP_ZERO = 2'd1;
  localparam logic [1:0] EXP_UP   = 2'd2;

  localparam int NEWTON_STEPS = 6;
  localparam int TERM_COUNT   = 12;

  // One term of the rate matrix product: delta[row] +/- q[qsel] * rate[col].
  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] qsel;
    logic       neg;
  } term_t;

  function automatic term_t term_of(input logic [3:0] op);
    term_t r;
    r = '0;
    case (op)
      4'd0:    r = '{row: 2'd0, col: 2'd0, qsel: 2'd1, neg: 1'b1};
      4'd1:    r = '{row: 2'd0, col: 2'd1, qsel: 2'd2, neg: 1'b1};
      4'd2:    r = '{row: 2'd0, col: 2'd2, qsel: 2'd3, neg: 1'b1};
      4'd3:    r = '{row: 2'd1, col: 2'd0, qsel: 2'd0, neg: 1'b0};
      4'd4:    r = '{row: 2'd1, col: 2'd1, qsel: 2'd3, neg: 1'b1};
      4'd5:    r = '{row: 2'd1, col: 2'd2, qsel: 2'd2, neg: 1'b0};
      4'd6:    r = '{row: 2'd2, col: 2'd0, qsel: 2'd3, neg: 1'b0};
      4'd7:    r = '{row: 2'd2, col: 2'd1, qsel: 2'd0, neg: 1'b0};
      4'd8:    r = '{row: 2'd2, col: 2'd2, qsel: 2'd1, neg: 1'b1};
      4'd9:    r = '{row: 2'd3, col: 2'd0, qsel: 2'd2, neg: 1'b1};
      4'd10:   r = '{row: 2'd3, col: 2'd1, qsel: 2'd1, neg: 1'b0};
      4'd11:   r = '{row: 2'd3, col: 2'd2, qsel: 2'd0, neg: 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/quaternion_gyro_propagation_unit.sv -----
`default_nettype none
// Attitude quaternion propagation from body rates, with renormalization.
// Input channel (in_valid/in_ready) carries rate_x, rate_y, rate_z in signed
// Q6.25 rad/s. Each accepted item advances the stored quaternion by one
// first-order step scaled by half_step_time, then rescales it to unit length
// with a six-step Newton inverse square root, and delivers one item on the
// output channel (out_valid/out_ready): quat_w..quat_z in signed Q2.30 and a
// degenerate flag that is set when the step gave an all-zero quaternion.
// All products go through one shared 34 x 34 multiplier with a registered
// product, under a small sequencer. Prescaling takes 0 to 29 one-bit shifts,
// and the degenerate case skips the square sum and the Newton steps; in_ready
// returns in the same cycle that out_valid rises. The block takes one item
// at a time. The output register holds a finished item, so a new item may
// be accepted while the receiver stalls; a second result then waits until
// the first is taken. The user must write half_step_time through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
// Reset restores the identity quaternion and half_step_time of 0.001 s.
module quaternion_gyro_propagation_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire         [31:0] cfg_wdata,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [31:0] rate_x,
  input  wire  signed [31:0] rate_y,
  input  wire  signed [31:0] rate_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               degenerate
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROP  = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_EXP   = 4'd5;
  localparam logic [3:0] S_NEWT  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] cnt;
  logic       phase;
  logic [1:0] sub;

  logic [31:0]        half_step_time;
  logic signed [31:0] q [4];
  logic signed [31:0] c [4];
  logic signed [40:0] d [4];
  logic signed [31:0] rate [3];
  logic [31:0]        lo;
  logic [62:0]        s;
  logic [32:0]        x;
  logic [31:0]        y;
  logic [31:0]        y2;
  logic [31:0]        t;
  logic [1:0]         exp_code;
  logic               deg;

  // Shared multiplier with registered product.
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;

  qgp_pkg::term_t term;
  logic [1:0]     comp;
  logic           out_load;

  assign term     = qgp_pkg::term_of(cnt);
  assign comp     = cnt[2:1];
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_PROP: begin
        ma = 34'(q[term.qsel]);
        mb = 34'(rate[term.col]);
      end
      S_SCALE: begin
        ma = cnt[0] ? 34'(signed'(d[comp][40:32])) : {2'b00, d[comp][31:0]};
        mb = {2'b00, half_step_time};
      end
      S_SQ: begin
        ma = 34'(c[cnt[1:0]]);
        mb = 34'(c[cnt[1:0]]);
      end
      S_NEWT: begin
        case (sub)
          2'd0: begin
            ma = {2'b00, y};
            mb = {2'b00, y};
          end
          2'd1: begin
            ma = {1'b0, x};
            mb = {2'b00, y2};
          end
          default: begin
            ma = {2'b00, y};
            mb = {2'b00, t};
          end
        endcase
      end
      S_OUT: begin
        ma = 34'(c[cnt[1:0]]);
        mb = {2'b00, y};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Results derived from the product register.
  logic signed [67:0] prod_sh25;
  logic signed [47:0] delta;
  logic signed [47:0] prop_sum;
  logic [33:0]        xy2;
  logic [31:0]        t_new;
  logic signed [67:0] prod_out;
  logic [62:0]        s_sq;

  assign prod_sh25 = prod >>> 25;
  assign delta     = 48'(signed'(prod[42:0])) + 48'(signed'({1'b0, lo}));
  assign prop_sum  = 48'(q[comp]) + delta;
  assign xy2       = prod[63:30];
  assign t_new     = (xy2 < qgp_pkg::THREE_QONE) ? 32'(qgp_pkg::THREE_QONE - xy2) : 32'd0;
  assign s_sq      = s + 63'(prod[62:2]);

  always_comb begin
    case (exp_code)
      qgp_pkg::EXP_DOWN: prod_out = prod >>> 29;
      qgp_pkg::EXP_UP:   prod_out = prod >>> 31;
      default:           prod_out = prod >>> 30;
    endcase
  end

  // Prescale tests on the propagated components.
  logic all_zero;
  logic all_small;

  always_comb begin
    all_zero  = 1'b1;
    all_small = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (c[i] != 32'sd0) begin
        all_zero = 1'b0;
      end
      if (qgp_pkg::mag32(c[i]) >= 32'h20000000) begin
        all_small = 1'b0;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_time <= qgp_pkg::HSTEP_RST;
    end else if (cfg_we) begin
      half_step_time <= cfg_wdata;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      phase     <= 1'b0;
      sub       <= '0;
      deg       <= 1'b0;
      out_valid <= 1'b0;
      q[0]      <= signed'(qgp_pkg::QONE);
      q[1]      <= '0;
      q[2]      <= '0;
      q[3]      <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rate[0] <= rate_x;
            rate[1] <= rate_y;
            rate[2] <= rate_z;
            for (int i = 0; i < 4; i++) begin
              d[i] <= '0;
            end
            cnt   <= '0;
            phase <= 1'b0;
            state <= S_PROP;
          end
        end

        // Accumulate the twelve rate-matrix terms.
        S_PROP: begin
          phase <= ~phase;
          if (phase) begin
            if (term.neg) begin
              d[term.row] <= d[term.row] - prod_sh25[40:0];
            end else begin
              d[term.row] <= d[term.row] + prod_sh25[40:0];
            end
            if (cnt == 4'(qgp_pkg::TERM_COUNT - 1)) begin
              cnt   <= '0;
              state <= S_SCALE;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end

        // Scale each delta by the half step, low word then high part.
        S_SCALE: begin
          phase <= ~phase;
          if (phase) begin
            if (!cnt[0]) begin
              lo <= prod[63:32];
            end else begin
              c[comp] <= qgp_pkg::sat32(prop_sum);
            end
            if (cnt == 4'd7) begin
              cnt   <= '0;
              state <= S_NORM;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end

        // Zero check, then shift all components up one bit at a time.
        S_NORM: begin
          if (all_zero) begin
            q[0]  <= signed'(qgp_pkg::QONE);
            q[1]  <= '0;
            q[2]  <= '0;
            q[3]  <= '0;
            deg   <= 1'b1;
            state <= S_DONE;
          end else if (all_small) begin
            for (int i = 0; i < 4; i++) begin
              c[i] <= c[i] <<< 1;
            end
          end else begin
            s     <= '0;
            cnt   <= '0;
            phase <= 1'b0;
            state <= S_SQ;
          end
        end

        // Sum of squares in Q.58.
        S_SQ: begin
          phase <= ~phase;
          if (phase) begin
            s <= s_sq;
            if (cnt == 4'd3) begin
              cnt   <= '0;
              state <= S_EXP;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end

        // Bring the sum into [1, 4] and pick the Newton start value.
        S_EXP: begin
          if (s[62:58] == 5'd0) begin
            exp_code <= qgp_pkg::EXP_DOWN;
            x        <= s[58:26];
            y        <= (s[58:57] == 2'd0) ? qgp_pkg::Y0_LOW : qgp_pkg::Y0_HIGH;
          end else if (s > (63'd1 << 60)) begin
            exp_code <= qgp_pkg::EXP_UP;
            x        <= s[62:30];
            y        <= (s[62:61] == 2'd0) ? qgp_pkg::Y0_LOW : qgp_pkg::Y0_HIGH;
          end else begin
            exp_code <= qgp_pkg::EXP_ZERO;
            x        <= s[60:28];
            y        <= (s[60:59] == 2'd0) ? qgp_pkg::Y0_LOW : qgp_pkg::Y0_HIGH;
          end
          cnt   <= '0;
          sub   <= '0;
          phase <= 1'b0;
          state <= S_NEWT;
        end

        // Newton steps for the inverse square root, three products each.
        S_NEWT: begin
          phase <= ~phase;
          if (phase) begin
            case (sub)
              2'd0:    y2 <= prod[61:30];
              2'd1:    t  <= t_new;
              default: y  <= prod[62:31];
            endcase
            if (sub == 2'd2) begin
              sub <= '0;
              if (cnt == 4'(qgp_pkg::NEWTON_STEPS - 1)) begin
                cnt   <= '0;
                state <= S_OUT;
              end else begin
                cnt <= cnt + 4'd1;
              end
            end else begin
              sub <= sub + 2'd1;
            end
          end
        end

        // Scale each component by the inverse norm and store it.
        S_OUT: begin
          phase <= ~phase;
          if (phase) begin
            q[cnt[1:0]] <= qgp_pkg::sat32(prod_out[47:0]);
            if (cnt == 4'd3) begin
              cnt   <= '0;
              deg   <= 1'b0;
              state <= S_DONE;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end

        // Hand the item to the output register once it is free.
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      quat_w     <= q[0];
      quat_x     <= q[1];
      quat_y     <= q[2];
      quat_z     <= q[3];
      degenerate <= deg;
    end
  end

endmodule
`default_nettype wire

// ----- dv/quaternion_gyro_propagation_unit_test.sv -----
`timescale 1ns / 1ps
module quaternion_gyro_propagation_unit_test;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT = 36;
  localparam int PHASE_COUNT = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam logic signed [31:0] RATE_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] RATE_MIN = 32'sh80000000;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        degen;
  } attitude_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
  } rate_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic        [31:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] rate_x = '0;
  logic signed [31:0] rate_y = '0;
  logic signed [31:0] rate_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic               degenerate;

  // Predictor state: its own attitude and half-step register.
  longint      att_q [4];
  logic [31:0] hstep_model;

  rate_item_t rate_items [$];
  attitude_t  expected_attitudes [$];
  int         items_pushed = 0;
  int         results_seen = 0;
  int         error_count = 0;
  int         idle_pct = IDLE_PCT;
  int         stall_cycles = 0;

  quaternion_gyro_propagation_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rate_x     (rate_x),
    .rate_y     (rate_y),
    .rate_z     (rate_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .quat_w     (quat_w),
    .quat_x     (quat_x),
    .quat_y     (quat_y),
    .quat_z     (quat_z),
    .degenerate (degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One rate-matrix term: a Q.55 product floored back to Q.30.
  function automatic longint rate_term(input longint qc, input longint rate);
    return (qc * rate) >>> 25;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Floor of s * h / 2^32, with h the unsigned Q0.32 half step.
  function automatic longint half_step_scale(input longint s);
    logic signed [96:0] p;
    p = s * $signed({1'b0, hstep_model});
    return longint'(p >>> 32);
  endfunction

  // Advances the predicted attitude by one rate item and returns the
  // normalized quaternion the block should deliver.
  function automatic attitude_t propagate_attitude(input logic signed [31:0] rx_in,
                                                   input logic signed [31:0] ry_in,
                                                   input logic signed [31:0] rz_in);
    longint          rx;
    longint          ry;
    longint          rz;
    longint          d [4];
    longint          c [4];
    longint unsigned m;
    longint unsigned a;
    longint unsigned s;
    longint unsigned x;
    longint unsigned y;
    longint unsigned y2;
    longint unsigned xy2;
    longint unsigned t;
    int              k;
    int              e;
    attitude_t       r;
    rx = rx_in;
    ry = ry_in;
    rz = rz_in;
    r.degen = 1'b0;

    // First-order step q += h * Omega(rate) * q.
    d[0] = -rate_term(att_q[1], rx) - rate_term(att_q[2], ry) - rate_term(att_q[3], rz);
    d[1] = rate_term(att_q[0], rx) - rate_term(att_q[3], ry) + rate_term(att_q[2], rz);
    d[2] = rate_term(att_q[3], rx) + rate_term(att_q[0], ry) - rate_term(att_q[1], rz);
    d[3] = -rate_term(att_q[2], rx) + rate_term(att_q[1], ry) + rate_term(att_q[0], rz);
    m = 0;
    for (int i = 0; i < 4; i++) begin
      c[i] = clamp32(att_q[i] + half_step_scale(d[i]));
      a = (c[i] < 0) ? -c[i] : c[i];
      if (a > m) m = a;
    end

    if (m == 0) begin
      // An all-zero step falls back to the identity.
      att_q[0] = longint'(qgp_pkg::QONE);
      att_q[1] = 0;
      att_q[2] = 0;
      att_q[3] = 0;
      r.degen = 1'b1;
    end else begin
      // Prescale so the largest magnitude reaches 2^29, then sum squares.
      k = 0;
      while (m < (64'd1 << 29) && k < 31) begin
        m = m << 1;
        k++;
      end
      s = 0;
      for (int i = 0; i < 4; i++) begin
        c[i] = c[i] <<< k;
        a = (c[i] < 0) ? -c[i] : c[i];
        s = s + ((a * a) >> 2);
      end
      e = 0;
      if (s < (64'd1 << 58)) begin
        s = s << 2;
        e = -1;
      end else if (s > (64'd1 << 60)) begin
        s = s >> 2;
        e = 1;
      end
      x = s >> 28;

      // Newton iteration for the inverse square root.
      y = (x < 2 * 64'(qgp_pkg::QONE)) ? 64'(qgp_pkg::Y0_LOW) : 64'(qgp_pkg::Y0_HIGH);
      for (int i = 0; i < qgp_pkg::NEWTON_STEPS; i++) begin
        y2 = (y * y) >> 30;
        xy2 = (x * y2) >> 30;
        t = (xy2 < 64'(qgp_pkg::THREE_QONE)) ? 64'(qgp_pkg::THREE_QONE) - xy2 : 64'd0;
        y = (y * t) >> 31;
      end
      for (int i = 0; i < 4; i++) begin
        att_q[i] = clamp32((c[i] * longint'(y)) >>> (30 + e));
      end
    end

    r.w = 32'(att_q[0]);
    r.x = 32'(att_q[1]);
    r.y = 32'(att_q[2]);
    r.z = 32'(att_q[3]);
    return r;
  endfunction

  // Mostly shifted-down values for realistic rates, with full range and the
  // extremes mixed in.
  function automatic logic signed [31:0] random_rate();
    logic signed [31:0] r;
    r = $urandom();
    case ($urandom_range(19))
      0: r = RATE_MAX;
      1: r = RATE_MIN;
      2: r = '0;
      default: r = r >>> $urandom_range(12);
    endcase
    return r;
  endfunction

  task automatic send_rates(input logic signed [31:0] rx, input logic signed [31:0] ry,
                            input logic signed [31:0] rz);
    rate_items.push_back('{rx, ry, rz});
    items_pushed++;
  endtask

  task automatic wait_for_results();
    while (results_seen < items_pushed) @(posedge clk);
  endtask

  // The register is written only once every result is back.
  task automatic write_half_step(input logic [31:0] value);
    wait_for_results();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver; it also predicts each item as it is accepted.
  always @(posedge clk) begin : drive_rates
    rate_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
      hstep_model <= qgp_pkg::HSTEP_RST;
      att_q[0] = longint'(qgp_pkg::QONE);
      att_q[1] = 0;
      att_q[2] = 0;
      att_q[3] = 0;
    end else begin
      if (cfg_we) hstep_model <= cfg_wdata;
      if (in_valid && in_ready) begin
        expected_attitudes.push_back(propagate_attitude(rate_x, rate_y, rate_z));
      end
      if (!in_valid || in_ready) begin
        if (rate_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_item = rate_items.pop_front();
          in_valid <= 1'b1;
          rate_x <= next_item.rx;
          rate_y <= next_item.ry;
          rate_z <= next_item.rz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Result monitor: each accepted item is compared with the oldest prediction.
  always @(posedge clk) begin : check_attitude
    attitude_t want;
    logic      bad;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_attitudes.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Unexpected result item: w=%0d x=%0d y=%0d z=%0d degenerate=%0b",
                   quat_w, quat_x, quat_y, quat_z, degenerate);
        end
      end else begin
        want = expected_attitudes.pop_front();
        bad = (quat_w !== want.w) || (quat_x !== want.x) || (quat_y !== want.y)
              || (quat_z !== want.z) || (degenerate !== want.degen);
        if (bad) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Mismatch on result %0d: expected w=%0d x=%0d y=%0d z=%0d degenerate=%0b",
                     results_seen, $signed(want.w), $signed(want.x), $signed(want.y),
                     $signed(want.z), want.degen);
            $display("  actual w=%0d x=%0d y=%0d z=%0d degenerate=%0b",
                     quat_w, quat_x, quat_y, quat_z, degenerate);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] hv;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero rate, single-axis and three-axis extremes and a tiny rate with the
    // reset half step. A unit quaternion can never step to all zeros, so the
    // degenerate flag is expected to stay low throughout.
    send_rates('0, '0, '0);
    send_rates(RATE_MAX, '0, '0);
    send_rates(RATE_MIN, '0, '0);
    send_rates('0, RATE_MAX, '0);
    send_rates('0, RATE_MIN, '0);
    send_rates('0, '0, RATE_MAX);
    send_rates('0, '0, RATE_MIN);
    send_rates(32'sd1, -32'sd1, 32'sd1);
    send_rates(RATE_MAX, RATE_MAX, RATE_MAX);
    send_rates(RATE_MIN, RATE_MIN, RATE_MIN);

    // Largest half step with large rates drives components into saturation.
    write_half_step(32'hffffffff);
    send_rates(RATE_MAX, '0, '0);
    send_rates(RATE_MIN, RATE_MAX, RATE_MIN);
    send_rates(RATE_MAX, RATE_MIN, RATE_MAX);
    send_rates(RATE_MIN, RATE_MIN, RATE_MIN);
    send_rates(32'sh04000000, '0, '0);

    // Zero half step leaves the attitude to renormalization alone.
    write_half_step(32'h0);
    send_rates(RATE_MAX, RATE_MAX, RATE_MAX);
    send_rates(RATE_MIN, '0, RATE_MAX);
    send_rates(random_rate(), random_rate(), random_rate());

    write_half_step(32'h1);
    send_rates(RATE_MAX, RATE_MIN, 32'sd1);

    // Random phases, each under its own half step; one runs without idling.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: hv = qgp_pkg::HSTEP_RST;
        3: hv = 32'hffffffff;
        5: hv = 32'h0;
        6: hv = $urandom();
        default: hv = $urandom_range(1, 32'h01000000);
      endcase
      write_half_step(hv);
      idle_pct = (ph == 4) ? 0 : IDLE_PCT;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_rates(random_rate(), random_rate(), random_rate());
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_attitudes.size() != 0) begin
      error_count += expected_attitudes.size();
      $display("%0d predicted result items never arrived", expected_attitudes.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- quaternion_gyro_propagation_unit.f -----
sv/qgp_pkg.sv
sv/quaternion_gyro_propagation_unit.sv
dv/quaternion_gyro_propagation_unit_test.sv
